@@ rtl/mhpq_pkg.sv @@
// shared types, codes and helpers for the min-heap priority queue
package mhpq_pkg;

  localparam int TIME_W           = 32;
  localparam int ID_W             = 16;
  localparam int COUNT_PORT_W     = 11;
  localparam int DEFAULT_CAPACITY = 1024;

  typedef struct packed {
    logic [TIME_W-1:0] key_time;
    logic [ID_W-1:0]   key_id;
  } entry_t;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_REMOVE = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL_DROP  = 2'd1,
    ST_EMPTY_REM  = 2'd2
  } status_t;

  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t key;
  } cell_cmd_t;

  function automatic logic entry_lt(entry_t a, entry_t b);
    return a < b;
  endfunction

endpackage

@@ rtl/min_heap_priority_queue.sv @@
// top level of the min-heap priority queue built as a sorted row of cells
//
//   channel | direction | payload                                        | handshake
//   in      | input     | req_type, new_time, new_id                     | in_valid / in_ready
//   out     | output    | min_time, min_id, entry_count, is_empty, status | out_valid / out_ready
//
// every cell acts in the cycle that accepts a beat: broadcast key compare and shift on insert, shift on remove
// the result is registered and shows in the cycle after the input beat is accepted
// in_ready is high whenever the result register is empty or being taken
// rst clears the entry count and the output valid; cell contents are left as they are
// a stalled result holds while the input side waits
module min_heap_priority_queue #(
  parameter int CAPACITY = mhpq_pkg::DEFAULT_CAPACITY
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              req_type,
  input  logic [mhpq_pkg::TIME_W-1:0]       new_time,
  input  logic [mhpq_pkg::ID_W-1:0]         new_id,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mhpq_pkg::TIME_W-1:0]       min_time,
  output logic [mhpq_pkg::ID_W-1:0]         min_id,
  output logic [mhpq_pkg::COUNT_PORT_W-1:0] entry_count,
  output logic                              is_empty,
  output logic [1:0]                        status
);
  import mhpq_pkg::*;

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int EXT_W = CNT_W + COUNT_PORT_W;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  entry_t           cell_q [CAPACITY];
  logic             occ    [CAPACITY];
  cell_cmd_t        cmd;
  entry_t           key;
  entry_t           head_next;
  status_t          st_next;
  logic             accept;
  logic             full;
  logic             empty;
  logic [EXT_W-1:0] count_ext;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = (count == CNT_W'(CAPACITY));
  assign empty    = (count == '0);
  assign key      = '{key_time: new_time, key_id: new_id};

  always_comb begin
    cmd        = '{ins: 1'b0, rem: 1'b0, key: key};
    count_next = count;
    st_next    = ST_DONE;
    head_next  = empty ? entry_t'('0) : cell_q[0];
    unique case (req_t'(req_type))
      REQ_INSERT: begin
        if (full) begin
          st_next = ST_FULL_DROP;
        end else begin
          cmd.ins    = accept;
          count_next = count + CNT_W'(1);
          if (empty || entry_lt(key, cell_q[0])) begin
            head_next = key;
          end
        end
      end
      REQ_REMOVE: begin
        if (empty) begin
          st_next = ST_EMPTY_REM;
        end else begin
          cmd.rem    = accept;
          count_next = count - CNT_W'(1);
          if (CAPACITY > 1 && count > CNT_W'(1)) begin
            head_next = cell_q[1];
          end else begin
            head_next = '0;
          end
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occ[i] = (CNT_W'(i) < count);
    if (i == 0) begin : g_head
      mhpq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .prev_q   ('0),
        .prev_occ (1'b0),
        .self_occ (occ[i]),
        .next_q   (cell_q[i+1]),
        .q        (cell_q[i])
      );
    end else if (i == CAPACITY - 1) begin : g_tail
      mhpq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .prev_q   (cell_q[i-1]),
        .prev_occ (occ[i-1]),
        .self_occ (occ[i]),
        .next_q   (cell_q[i]),
        .q        (cell_q[i])
      );
    end else begin : g_mid
      mhpq_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .prev_q   (cell_q[i-1]),
        .prev_occ (occ[i-1]),
        .self_occ (occ[i]),
        .next_q   (cell_q[i+1]),
        .q        (cell_q[i])
      );
    end
  end

  assign count_ext = {{COUNT_PORT_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      min_time    <= head_next.key_time;
      min_id      <= head_next.key_id;
      entry_count <= count_ext[COUNT_PORT_W-1:0];
      is_empty    <= (count_next == '0);
      status      <= st_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_INSERT && !full) |=> count == $past(count) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_empty) |-> (min_time == '0 && min_id == '0))
    else $error("empty result carries a nonzero entry");

  a_rem_empty: assert property (@(posedge clk) disable iff (rst)
    (accept && req_type == REQ_REMOVE && empty) |=> (count == '0 && status == ST_EMPTY_REM))
    else $error("remove on empty heap mishandled");

  a_row_sorted: assert property (@(posedge clk) disable iff (rst)
    (CAPACITY > 1 && count > CNT_W'(1)) |-> !entry_lt(cell_q[1], cell_q[0]))
    else $error("cell row out of order at the head");

endmodule

@@ rtl/mhpq_cell.sv @@
// one slot of the sorted cell row, shifts toward the tail on insert, toward the head on remove
module mhpq_cell (
  input  logic               clk,
  input  mhpq_pkg::cell_cmd_t cmd,
  input  mhpq_pkg::entry_t   prev_q,
  input  logic               prev_occ,
  input  logic               self_occ,
  input  mhpq_pkg::entry_t   next_q,
  output mhpq_pkg::entry_t   q
);
  import mhpq_pkg::*;

  logic take_prev;
  logic take_key;

  assign take_prev = prev_occ && entry_lt(cmd.key, prev_q);
  assign take_key  = !self_occ || entry_lt(cmd.key, q);

  always_ff @(posedge clk) begin
    if (cmd.ins) begin
      if (take_prev) begin
        q <= prev_q;
      end else if (take_key) begin
        q <= cmd.key;
      end
    end else if (cmd.rem) begin
      q <= next_q;
    end
  end

endmodule
